@@ rtl/core/averaged_reading_plausibility_check_defines.svh @@
// Assertion macros used by the checker of the reading plausibility check.
`ifndef AVERAGED_READING_PLAUSIBILITY_CHECK_DEFINES_SVH
`define AVERAGED_READING_PLAUSIBILITY_CHECK_DEFINES_SVH

// same-cycle implication
`define ARPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpc: same-cycle check failed");

// next-cycle implication
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpc: next-cycle check failed");

`endif

@@ rtl/core/arpc_pkg.sv @@
// Shared constants, payload types and control struct of the reading plausibility check.
package arpc_pkg;

   // batch size (2 to 8)
   localparam int SAMPLES = 3;

   localparam int T_W    = 16;
   localparam int H_W    = 10;
   localparam int IDX_W  = $clog2(SAMPLES);
   localparam int SUM_W  = T_W + $clog2(SAMPLES);

   // divide by SAMPLES as multiply by a rounded-up reciprocal, then shift;
   // the rounding error stays below 8, so three extra shift bits keep every
   // quotient of a SUM_W-bit magnitude exact
   localparam int DIV_SHIFT = SUM_W + 3;
   localparam int PROD_W    = SUM_W + DIV_SHIFT;
   localparam logic [DIV_SHIFT-1:0] DIV_MULT =
      DIV_SHIFT'((2**DIV_SHIFT + SAMPLES - 1) / SAMPLES);

   // register file
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_TCUT = 1'b0;
   localparam logic REG_HCUT = 1'b1;
   localparam logic [T_W-1:0] TCUT_RESET = 16'd10;
   localparam logic [H_W-1:0] HCUT_RESET = 10'd100;

   typedef struct packed {
      logic signed [T_W-1:0] temperature;
      logic [H_W-1:0]        humidity;
      logic                  read_failed;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic signed [T_W-1:0] mean_temperature;
      logic [H_W-1:0]        mean_humidity;
   } rsp_type;

   // sequencer to arithmetic unit
   typedef struct packed {
      logic acc_clear;
      logic acc_en;
      logic div_temp;
      logic div_hum;
      logic mean_load;
      logic chk_clear;
      logic chk_en;
   } ctrl_type;

endpackage

@@ rtl/core/arpc_store.sv @@
// Sample registers of the current batch: one write port, one indexed read.
module arpc_store
   import arpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_idx,
   input  logic signed [T_W-1:0] wr_temp,
   input  logic [H_W-1:0]        wr_hum,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic signed [T_W-1:0] rd_temp,
   output logic [H_W-1:0]        rd_hum
);

   logic signed [T_W-1:0] temp_ff [SAMPLES];
   logic [H_W-1:0]        hum_ff  [SAMPLES];

   // sample write, no reset needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         temp_ff[wr_idx] <= wr_temp;
         hum_ff[wr_idx]  <= wr_hum;
      end
   end

   assign rd_temp = temp_ff[rd_idx];
   assign rd_hum  = hum_ff[rd_idx];

endmodule

@@ rtl/core/arpc_alu.sv @@
// Shared arithmetic unit: accumulate, reciprocal-multiply divide by the batch size, deviation check.
module arpc_alu
   import arpc_pkg::*;
(
   input  logic                  clock,
   input  ctrl_type              ctrl,
   input  logic signed [T_W-1:0] smp_temp,
   input  logic [H_W-1:0]        smp_hum,
   input  logic [T_W-1:0]        temp_cutoff,
   input  logic [H_W-1:0]        hum_cutoff,
   output logic signed [T_W-1:0] mean_temp,
   output logic [H_W-1:0]        mean_hum,
   output logic                  batch_ok
);

   logic signed [SUM_W-1:0] sum_t_ff, sum_t_in;
   logic [SUM_W-1:0]        sum_h_ff, sum_h_in;
   logic [SUM_W-1:0]        qt_ff, qt_in, qh_ff, qh_in;
   logic                    neg_ff, neg_in;
   logic signed [T_W-1:0]   mean_t_ff, mean_t_in;
   logic [H_W-1:0]          mean_h_ff, mean_h_in;
   logic                    ok_ff, ok_in;

   logic [SUM_W-1:0]        sum_t_neg;
   logic [SUM_W-1:0]        qt_neg;
   logic [SUM_W-1:0]        mul_op;
   logic [PROD_W-1:0]       prod;
   logic [SUM_W-1:0]        quo;
   logic signed [T_W:0]     dev_t;
   logic [T_W:0]            mag_t;
   logic signed [H_W:0]     dev_h;
   logic [H_W:0]            mag_h;
   logic                    bad;

   // deviation of the addressed sample from the stored means
   always_comb begin
      dev_t = {mean_t_ff[T_W-1], mean_t_ff} - {smp_temp[T_W-1], smp_temp};
      mag_t = dev_t[T_W] ? (T_W + 1)'(-dev_t) : (T_W + 1)'(dev_t);
      dev_h = {1'b0, mean_h_ff} - {1'b0, smp_hum};
      mag_h = dev_h[H_W] ? (H_W + 1)'(-dev_h) : (H_W + 1)'(dev_h);
      bad   = (mag_t > {1'b0, temp_cutoff}) || (mag_h > {1'b0, hum_cutoff});
   end

   always_comb begin
      sum_t_neg = -sum_t_ff;
      qt_neg    = -qt_ff;

      // one shared multiplier: temperature magnitude first, humidity next
      mul_op = ctrl.div_hum ? sum_h_ff : (sum_t_ff[SUM_W-1] ? sum_t_neg : sum_t_ff);
      prod   = PROD_W'(mul_op) * PROD_W'(DIV_MULT);
      quo    = SUM_W'(prod >> DIV_SHIFT);

      sum_t_in  = sum_t_ff;
      sum_h_in  = sum_h_ff;
      qt_in     = qt_ff;
      qh_in     = qh_ff;
      neg_in    = neg_ff;
      mean_t_in = mean_t_ff;
      mean_h_in = mean_h_ff;
      ok_in     = ok_ff;

      // accumulate
      if (ctrl.acc_clear) begin
         sum_t_in = '0;
         sum_h_in = '0;
      end else if (ctrl.acc_en) begin
         sum_t_in = sum_t_ff + SUM_W'(smp_temp);
         sum_h_in = sum_h_ff + SUM_W'(smp_hum);
      end

      // divide magnitudes, sign restored afterwards (truncation toward zero)
      if (ctrl.div_temp) begin
         neg_in = sum_t_ff[SUM_W-1];
         qt_in  = quo;
      end
      if (ctrl.div_hum) begin
         qh_in = quo;
      end

      if (ctrl.mean_load) begin
         mean_t_in = neg_ff ? qt_neg[T_W-1:0] : qt_ff[T_W-1:0];
         mean_h_in = qh_ff[H_W-1:0];
      end

      // deviation check
      if (ctrl.chk_clear) begin
         ok_in = 1'b1;
      end else if (ctrl.chk_en) begin
         ok_in = ok_ff & ~bad;
      end
   end

   always_ff @(posedge clock) begin
      sum_t_ff  <= sum_t_in;
      sum_h_ff  <= sum_h_in;
      qt_ff     <= qt_in;
      qh_ff     <= qh_in;
      neg_ff    <= neg_in;
      mean_t_ff <= mean_t_in;
      mean_h_ff <= mean_h_in;
      ok_ff     <= ok_in;
   end

   assign mean_temp = mean_t_ff;
   assign mean_hum  = mean_h_ff;
   assign batch_ok  = ok_ff;

endmodule

@@ rtl/core/arpc_seq.sv @@
// Sequencer: batch fill, then accumulate, divide, check and hand off the result.
module arpc_seq
   import arpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_take,
   input  logic             req_failed,
   input  logic             rsp_free,
   output logic             busy,
   output ctrl_type         ctrl,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_idx,
   output logic [IDX_W-1:0] rd_idx,
   output logic             rsp_load
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ACC   = 3'd1;
   localparam logic [2:0] ST_DIV_T = 3'd2;
   localparam logic [2:0] ST_DIV_H = 3'd3;
   localparam logic [2:0] ST_MEAN  = 3'd4;
   localparam logic [2:0] ST_CHK   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      ctrl     = '0;
      wr_en    = 1'b0;
      rsp_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && !req_failed) begin
               wr_en = 1'b1;
               if (fill_ff == IDX_LAST) begin
                  fill_in        = '0;
                  idx_in         = '0;
                  ctrl.acc_clear = 1'b1;
                  state_in       = ST_ACC;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_ACC: begin
            ctrl.acc_en = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            ctrl.div_temp = 1'b1;
            state_in      = ST_DIV_H;
         end
         ST_DIV_H: begin
            ctrl.div_hum = 1'b1;
            state_in     = ST_MEAN;
         end
         ST_MEAN: begin
            ctrl.mean_load = 1'b1;
            ctrl.chk_clear = 1'b1;
            idx_in         = '0;
            state_in       = ST_CHK;
         end
         ST_CHK: begin
            ctrl.chk_en = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign wr_idx = fill_ff;
   assign rd_idx = idx_ff;

endmodule

@@ rtl/core/averaged_reading_plausibility_check.sv @@
// Top level of the reading plausibility check: register port, result register, core units.
//
//   channel  direction  handshake             beat
//   req_     in         req_valid/req_stall   req_type (temperature, humidity, read_failed)
//   rsp_     out        rsp_valid/rsp_stall   rsp_type (accepted, means)
//   csr_     in/out     APB psel/penable      cutoff registers at 0x0, 0x4 on 32-bit data
//
// A failed read or a beat that does not complete a batch is taken without raising req_stall.
// The beat that completes a batch raises req_stall for the per-sample accumulate
// and check passes, one shared reciprocal multiply per mean, the mean load and the
// result hand-off, plus any wait for the result register to free up.
// New beats are taken while a finished result waits on rsp_stall.
// Synchronous reset empties the batch and restores the cutoffs; sample data is not cleared.
module averaged_reading_plausibility_check
   import arpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [T_W-1:0]        tcut_ff, tcut_in;
   logic [H_W-1:0]        hcut_ff, hcut_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  csr_wr;
   logic                  req_take;
   logic                  rsp_free;
   logic                  busy;
   ctrl_type              ctrl;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [IDX_W-1:0]      rd_idx;
   logic                  rsp_load;
   logic signed [T_W-1:0] smp_temp;
   logic [H_W-1:0]        smp_hum;
   logic signed [T_W-1:0] mean_temp;
   logic [H_W-1:0]        mean_hum;
   logic                  batch_ok;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // cutoff registers
   always_comb begin
      tcut_in = tcut_ff;
      hcut_in = hcut_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_TCUT: tcut_in = csr_pwdata[T_W-1:0];
            REG_HCUT: hcut_in = csr_pwdata[H_W-1:0];
            default: begin
               tcut_in = tcut_ff;
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[2])
         REG_TCUT: csr_prdata = DATA_W'(tcut_ff);
         REG_HCUT: csr_prdata = DATA_W'(hcut_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign req_take  = req_valid & ~req_stall;
   assign req_stall = busy;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.accepted         = batch_ok;
         rsp_data_in.mean_temperature = mean_temp;
         rsp_data_in.mean_humidity    = mean_hum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcut_ff      <= TCUT_RESET;
         hcut_ff      <= HCUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tcut_ff      <= tcut_in;
         hcut_ff      <= hcut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   arpc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req_failed (req_data.read_failed),
      .rsp_free   (rsp_free),
      .busy       (busy),
      .ctrl       (ctrl),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .rd_idx     (rd_idx),
      .rsp_load   (rsp_load)
   );

   arpc_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_temp (req_data.temperature),
      .wr_hum  (req_data.humidity),
      .rd_idx  (rd_idx),
      .rd_temp (smp_temp),
      .rd_hum  (smp_hum)
   );

   arpc_alu u_alu (
      .clock       (clock),
      .ctrl        (ctrl),
      .smp_temp    (smp_temp),
      .smp_hum     (smp_hum),
      .temp_cutoff (tcut_ff),
      .hum_cutoff  (hcut_ff),
      .mean_temp   (mean_temp),
      .mean_hum    (mean_hum),
      .batch_ok    (batch_ok)
   );

endmodule

@@ rtl/core/arpc_checker.sv @@
// Port-level checker for the reading plausibility check, bound to the top level.
`include "averaged_reading_plausibility_check_defines.svh"

module arpc_checker
   import arpc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat stays and holds its payload
   `ARPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a new result only appears while the input side is held off by batch math
   `ARPC_ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // a failed read never starts batch processing
   `ARPC_ASSERT_NEXT(a_failed_no_busy, clock, reset, req_valid && !req_stall && req_data.read_failed, !req_stall)

endmodule

bind averaged_reading_plausibility_check arpc_checker u_arpc_checker (.*);
